[rtl/vector_refraction_3d_macros.svh]
// Assertion macros shared by the checker of vector_refraction_3d.
// No dependencies.
`ifndef VECTOR_REFRACTION_3D_MACROS_SVH
`define VECTOR_REFRACTION_3D_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define VR3D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vr3d check failed");

// Antecedent implies consequent in the next cycle.
`define VR3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vr3d check failed");

`endif

[rtl/vr3d_pkg.sv]
// Shared types, constants and saturation helper for vector_refraction_3d.
// No dependencies.
package vr3d_pkg;

    localparam int INT_W = 32;
    localparam int WIDE_W = 66;

    // Pipeline control handed to the square root stages
    typedef struct packed {
        logic advance;
        logic valid;
    } t_stage_ctl;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [INT_W-1:0] sat_i32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh0000_0000_7fff_ffff);
        lo = -WIDE_W'(64'sh0000_0000_8000_0000);
        if (x > hi) begin
            return 32'sh7fff_ffff;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[INT_W-1:0];
    endfunction

endpackage

[rtl/vr3d_sqrt.sv]
// Pipelined restoring integer square root, one root bit per stage.
// Depends on vr3d_pkg for the stage control struct.
module vr3d_sqrt
    import vr3d_pkg::*;
#(
    parameter int RW = 46,
    parameter int SW = 160
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    input  logic [RW-1:0]       i_rad,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [RW/2-1:0]     o_root,
    output logic [SW-1:0]       o_side
);

    localparam int SQ = RW / 2;

    logic [SQ+1:0] r_rem  [SQ];
    logic [SQ-1:0] r_root [SQ];
    logic [RW-1:0] r_rad  [SQ];
    logic [SW-1:0] r_side [SQ];
    logic          r_vld  [SQ];

    for (genvar j = 0; j < SQ; j++) begin : g_stage
        logic [SQ+1:0] p_rem;
        logic [SQ-1:0] p_root;
        logic [RW-1:0] p_rad;
        logic [SW-1:0] p_side;
        logic          p_vld;
        logic [SQ+1:0] cur;
        logic [SQ+1:0] trial;

        if (j == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
            assign p_vld  = i_ctl.valid;
        end else begin : g_next
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
            assign p_rad  = r_rad[j-1];
            assign p_side = r_side[j-1];
            assign p_vld  = r_vld[j-1];
        end

        // Bring down the next two radicand bits and try the next root bit
        assign cur   = {p_rem[SQ-1:0], p_rad[RW-1:RW-2]};
        assign trial = {p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_ctl.advance) begin
                r_vld[j] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.advance) begin
                if (cur >= trial) begin
                    r_rem[j]  <= cur - trial;
                    r_root[j] <= {p_root[SQ-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= cur;
                    r_root[j] <= {p_root[SQ-2:0], 1'b0};
                end
                r_rad[j]  <= {p_rad[RW-3:0], 2'b00};
                r_side[j] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[SQ-1];
    assign o_root  = r_root[SQ-1];
    assign o_side  = r_side[SQ-1];

endmodule

[rtl/vector_refraction_3d.sv]
// Top level of the 3D refraction pipeline (Snell's law, signed fixed point).
// Depends on vr3d_pkg and vr3d_sqrt.
//
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_ready   | i_inc_*, i_norm_*, i_eta
//  output  | out       | o_valid / i_ready   | o_out_*, o_total_reflection
//
// One item enters per cycle while the output is not stalled; items pass
// through stages 1 to 5, the one-bit-per-stage square root and stages A to C.
// Synchronous active-low reset clears all stage valid bits.
// A stall at the output freezes every stage at once; o_ready drops only
// while a result is waiting and i_ready is low.
module vector_refraction_3d
    import vr3d_pkg::*;
#(
    parameter int FRAC_BITS  = 14,
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COMP_WIDTH-1:0] i_inc_x,
    input  logic signed [COMP_WIDTH-1:0] i_inc_y,
    input  logic signed [COMP_WIDTH-1:0] i_inc_z,
    input  logic signed [COMP_WIDTH-1:0] i_norm_x,
    input  logic signed [COMP_WIDTH-1:0] i_norm_y,
    input  logic signed [COMP_WIDTH-1:0] i_norm_z,
    input  logic        [COMP_WIDTH-1:0] i_eta,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COMP_WIDTH-1:0] o_out_x,
    output logic signed [COMP_WIDTH-1:0] o_out_y,
    output logic signed [COMP_WIDTH-1:0] o_out_z,
    output logic                         o_total_reflection
);

    localparam int F  = FRAC_BITS;
    localparam int W  = COMP_WIDTH;
    localparam int SQ = (F + 33) / 2;
    localparam int RW = 2 * SQ;
    localparam int PW = INT_W + W;
    localparam int SW = 6 * W + 2 * INT_W + 1;
    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< F;

    // Clamp to the signed component range
    function automatic logic signed [W-1:0] sat_comp(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) <<< (W - 1)) - WIDE_W'(1);
        lo = -(WIDE_W'(1) <<< (W - 1));
        if (x > hi) begin
            return hi[W-1:0];
        end else if (x < lo) begin
            return lo[W-1:0];
        end
        return x[W-1:0];
    endfunction

    logic advance;
    logic r_out_valid;

    // Whole pipeline moves together unless the held result is not taken
    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;

    logic signed [INT_W-1:0] eta_c;
    assign eta_c = sat_i32(WIDE_W'(i_eta));

    // Stage 1: component products and eta squared
    logic                    r1_v;
    logic signed [2*W-1:0]   r1_px, r1_py, r1_pz;
    logic signed [63:0]      r1_e2p;
    logic signed [W-1:0]     r1_ix, r1_iy, r1_iz, r1_nx, r1_ny, r1_nz;
    logic signed [INT_W-1:0] r1_eta;

    // Stage 2: dot product and eta squared rescaled
    logic                    r2_v;
    logic signed [INT_W-1:0] r2_d, r2_e2, r2_eta;
    logic signed [W-1:0]     r2_ix, r2_iy, r2_iz, r2_nx, r2_ny, r2_nz;

    // Stage 3: d squared and eta times d
    logic                    r3_v;
    logic signed [63:0]      r3_ddp, r3_edp;
    logic signed [INT_W-1:0] r3_e2, r3_eta;
    logic signed [W-1:0]     r3_ix, r3_iy, r3_iz, r3_nx, r3_ny, r3_nz;

    // Stage 4: one minus d squared and eta times d rescaled
    logic                    r4_v;
    logic signed [INT_W-1:0] r4_t1, r4_ed, r4_e2, r4_eta;
    logic signed [W-1:0]     r4_ix, r4_iy, r4_iz, r4_nx, r4_ny, r4_nz;

    // Stage 5: scaled term product
    logic                    r5_v;
    logic signed [63:0]      r5_tp;
    logic signed [INT_W-1:0] r5_ed, r5_eta;
    logic signed [W-1:0]     r5_ix, r5_iy, r5_iz, r5_nx, r5_ny, r5_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (advance) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_px  <= i_inc_x * i_norm_x;
            r1_py  <= i_inc_y * i_norm_y;
            r1_pz  <= i_inc_z * i_norm_z;
            r1_e2p <= eta_c * eta_c;
            r1_eta <= eta_c;
            r1_ix  <= i_inc_x;
            r1_iy  <= i_inc_y;
            r1_iz  <= i_inc_z;
            r1_nx  <= i_norm_x;
            r1_ny  <= i_norm_y;
            r1_nz  <= i_norm_z;

            r2_d   <= sat_i32(WIDE_W'(r1_px >>> F) + WIDE_W'(r1_py >>> F)
                              + WIDE_W'(r1_pz >>> F));
            r2_e2  <= sat_i32(WIDE_W'(r1_e2p >>> F));
            r2_eta <= r1_eta;
            r2_ix  <= r1_ix;
            r2_iy  <= r1_iy;
            r2_iz  <= r1_iz;
            r2_nx  <= r1_nx;
            r2_ny  <= r1_ny;
            r2_nz  <= r1_nz;

            r3_ddp <= r2_d * r2_d;
            r3_edp <= r2_eta * r2_d;
            r3_e2  <= r2_e2;
            r3_eta <= r2_eta;
            r3_ix  <= r2_ix;
            r3_iy  <= r2_iy;
            r3_iz  <= r2_iz;
            r3_nx  <= r2_nx;
            r3_ny  <= r2_ny;
            r3_nz  <= r2_nz;

            r4_t1  <= sat_i32(ONE - WIDE_W'(sat_i32(WIDE_W'(r3_ddp >>> F))));
            r4_ed  <= sat_i32(WIDE_W'(r3_edp >>> F));
            r4_e2  <= r3_e2;
            r4_eta <= r3_eta;
            r4_ix  <= r3_ix;
            r4_iy  <= r3_iy;
            r4_iz  <= r3_iz;
            r4_nx  <= r3_nx;
            r4_ny  <= r3_ny;
            r4_nz  <= r3_nz;

            r5_tp  <= r4_e2 * r4_t1;
            r5_ed  <= r4_ed;
            r5_eta <= r4_eta;
            r5_ix  <= r4_ix;
            r5_iy  <= r4_iy;
            r5_iz  <= r4_iz;
            r5_nx  <= r4_nx;
            r5_ny  <= r4_ny;
            r5_nz  <= r4_nz;
        end
    end

    // Form k, flag total reflection and build the root radicand
    logic signed [INT_W-1:0] k;
    logic                    tir;
    logic [RW-1:0]           rad;
    logic [SW-1:0]           side_in;
    t_stage_ctl              sq_ctl;

    assign k   = sat_i32(ONE - WIDE_W'(sat_i32(WIDE_W'(r5_tp >>> F))));
    assign tir = (k <= 0);
    assign rad = tir ? '0 : (RW'($unsigned(k)) << F);
    assign side_in = {r5_ix, r5_iy, r5_iz, r5_nx, r5_ny, r5_nz, r5_eta, r5_ed, tir};
    assign sq_ctl.advance = advance;
    assign sq_ctl.valid   = r5_v;

    logic          sq_valid;
    logic [SQ-1:0] sq_root;
    logic [SW-1:0] sq_side;

    vr3d_sqrt #(
        .RW (RW),
        .SW (SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_rad   (rad),
        .i_side  (side_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic signed [W-1:0]     s_ix, s_iy, s_iz, s_nx, s_ny, s_nz;
    logic signed [INT_W-1:0] s_eta, s_ed;
    logic                    s_tir;
    assign {s_ix, s_iy, s_iz, s_nx, s_ny, s_nz, s_eta, s_ed, s_tir} = sq_side;

    // Stage A: bracket sum
    logic                    ra_v, ra_tir;
    logic signed [INT_W-1:0] ra_r, ra_eta;
    logic signed [W-1:0]     ra_ix, ra_iy, ra_iz, ra_nx, ra_ny, ra_nz;

    // Stage B: final products
    logic                    rb_v, rb_tir;
    logic signed [PW-1:0]    rb_ax, rb_ay, rb_az, rb_bx, rb_by, rb_bz;

    // Stage C: output register, with the difference or a zero vector on reflection
    logic signed [W-1:0]     r_out_x, r_out_y, r_out_z;
    logic                    r_out_tir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v        <= 1'b0;
            rb_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            ra_v        <= sq_valid;
            rb_v        <= ra_v;
            r_out_valid <= rb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            ra_r   <= sat_i32(WIDE_W'(s_ed) + WIDE_W'(sq_root));
            ra_tir <= s_tir;
            ra_eta <= s_eta;
            ra_ix  <= s_ix;
            ra_iy  <= s_iy;
            ra_iz  <= s_iz;
            ra_nx  <= s_nx;
            ra_ny  <= s_ny;
            ra_nz  <= s_nz;

            rb_ax  <= ra_eta * ra_ix;
            rb_ay  <= ra_eta * ra_iy;
            rb_az  <= ra_eta * ra_iz;
            rb_bx  <= ra_nx * ra_r;
            rb_by  <= ra_ny * ra_r;
            rb_bz  <= ra_nz * ra_r;
            rb_tir <= ra_tir;

            if (rb_tir) begin
                r_out_x <= '0;
                r_out_y <= '0;
                r_out_z <= '0;
            end else begin
                r_out_x <= sat_comp(WIDE_W'(rb_ax >>> F) - WIDE_W'(rb_bx >>> F));
                r_out_y <= sat_comp(WIDE_W'(rb_ay >>> F) - WIDE_W'(rb_by >>> F));
                r_out_z <= sat_comp(WIDE_W'(rb_az >>> F) - WIDE_W'(rb_bz >>> F));
            end
            r_out_tir <= rb_tir;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_out_x            = r_out_x;
    assign o_out_y            = r_out_y;
    assign o_out_z            = r_out_z;
    assign o_total_reflection = r_out_tir;

endmodule

[rtl/vr3d_checker.sv]
// Port-level checker for vector_refraction_3d, attached by bind.
// Depends on vector_refraction_3d_macros.svh.
`include "vector_refraction_3d_macros.svh"

module vr3d_checker #(
    parameter int COMP_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [COMP_WIDTH-1:0] o_out_x,
    input logic [COMP_WIDTH-1:0] o_out_y,
    input logic [COMP_WIDTH-1:0] o_out_z,
    input logic                  o_total_reflection
);

    // Hold a stalled result
    `VR3D_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_total_reflection))

    // Reflection results carry a zero vector
    `VR3D_ASSERT_SAME(a_tir_zero, i_clk, i_rst_n, o_valid && o_total_reflection, o_out_x == '0 && o_out_y == '0 && o_out_z == '0)

    // Input side stalls exactly when a held result is refused
    `VR3D_ASSERT_SAME(a_ready, i_clk, i_rst_n, 1'b1, o_ready == (!o_valid || i_ready))

    // Reset empties the pipeline
    `VR3D_ASSERT_NEXT(a_reset, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

bind vector_refraction_3d vr3d_checker #(.COMP_WIDTH(COMP_WIDTH)) u_vr3d_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_out_x            (o_out_x),
    .o_out_y            (o_out_y),
    .o_out_z            (o_out_z),
    .o_total_reflection (o_total_reflection)
);
